@@ design/page_translation_cache_promote_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the page translation cache
// Implication checks on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_TRANSLATION_CACHE_PROMOTE_CORE_MACROS_SVH
`define PAGE_TRANSLATION_CACHE_PROMOTE_CORE_MACROS_SVH

// same-cycle implication
`define PTCP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/ptcp_pkg.sv @@
// ----------------------------------------------------------------------------
// ptcp_pkg
// Beat types, field widths and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptcp_pkg;

	localparam int ADDR_W   = 64;
	localparam int OFFSET_W = 12;
	localparam int PAGE_W   = 52;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] virt_addr;
		logic              write_access;
		logic [PAGE_W-1:0] host_page_base;
	} req_beat_t;

	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] host_addr;
	} rsp_beat_t;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_FILL   = 1'b1;

	typedef struct packed {
		logic accept;
		logic scan;
		logic hold_hit;
		logic swap_rd;
		logic swap_a;
		logic swap_b;
		logic fill;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic req_fill;
		logic hit;
		logic promote;
		logic miss_end;
		logic out_busy;
	} stat_t;

endpackage

@@ design/page_translation_cache_promote_core.sv @@
// ----------------------------------------------------------------------------
// page_translation_cache_promote_core
// Fully associative page translation cache with rotating insert pointer and
// promotion of far hits to the slot just before the pointer.
//
//   channel | signals                     | beat
//   --------+-----------------------------+---------------------------------
//   req     | req_valid, req_stall, req   | lookup or fill request
//   rsp     | rsp_valid, rsp_stall, rsp   | hit flag and host address
//
// Fill: accept, write of the slot before the pointer, result load. Lookup:
// scan, a swap (read, two writes) for a hit at step PROMOTE_DISTANCE or more,
// result load. The scan reads one entry of the entry memory per cycle.
// Reset clears valid bits and the insert pointer; entry contents are not reset.
// A stalled result holds in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_translation_cache_promote_core
	import ptcp_pkg::*;
#(
	parameter int ENTRIES          = 16,
	parameter int PROMOTE_DISTANCE = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	cmd_t  cmd;
	stat_t stat;

	ptcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ptcp_dpath #(
		.ENTRIES          (ENTRIES),
		.PROMOTE_DISTANCE (PROMOTE_DISTANCE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ design/ptcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptcp_ctrl
// Sequencer for accept, circular scan, promotion swap, fill and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptcp_ctrl
	import ptcp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_SWAP_RD,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = (stat.req_fill == KIND_FILL) ? ST_FILL : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.hit) begin
					cmd.hold_hit = 1'b1;
					state_d      = stat.promote ? ST_SWAP_RD : ST_DONE;
				end else if (stat.miss_end) begin
					state_d = ST_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				state_d  = ST_DONE;
			end
			ST_SWAP_RD: begin
				cmd.swap_rd = 1'b1;
				state_d     = ST_SWAP_A;
			end
			ST_SWAP_A: begin
				cmd.swap_a = 1'b1;
				state_d    = ST_SWAP_B;
			end
			ST_SWAP_B: begin
				cmd.swap_b = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign req_stall = busy_q;

endmodule

@@ design/ptcp_dpath.sv @@
// ----------------------------------------------------------------------------
// ptcp_dpath
// Entry memory, valid bits, insert pointer, scan compare and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptcp_dpath
	import ptcp_pkg::*;
#(
	parameter int ENTRIES          = 16,
	parameter int PROMOTE_DISTANCE = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_beat_t req,
	input  cmd_t      cmd,
	output stat_t     stat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef struct packed {
		logic              writable;
		logic [PAGE_W-1:0] tag;
		logic [PAGE_W-1:0] host;
	} entry_t;

	entry_t            mem [ENTRIES];
	entry_t            rdata_s1;
	entry_t            hit_ent_q;
	entry_t            wr_data;
	req_beat_t         req_q;
	rsp_beat_t         rsp_q;
	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0]     ptr_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     idx_s1;
	logic [IW-1:0]     step_s1;
	logic [IW-1:0]     hit_idx_q;
	logic [IW-1:0]     slot;
	logic [IW-1:0]     wr_addr;
	logic [IW-1:0]     rd_addr;
	logic [CW-1:0]     iss_q;
	logic              live_s1;
	logic              vbit_s1;
	logic              hit_q;
	logic              rsp_valid_q;
	logic              rd_en;
	logic              we;
	logic              issue;
	logic              hit_now;
	logic [PAGE_W-1:0] vpage;

	assign vpage = req_q.virt_addr[ADDR_W-1:OFFSET_W];
	assign slot  = (ptr_q == '0) ? IW'(ENTRIES - 1) : ptr_q - IW'(1);
	assign issue = cmd.scan && (iss_q < CW'(ENTRIES));

	assign hit_now = live_s1 && vbit_s1 && (rdata_s1.tag == vpage)
		&& (rdata_s1.writable || !req_q.write_access);

	always_comb begin
		stat          = '0;
		stat.req_fill = req.kind;
		stat.hit      = hit_now;
		stat.promote  = (32'(step_s1) >= PROMOTE_DISTANCE);
		stat.miss_end = live_s1 && !hit_now && (step_s1 == IW'(ENTRIES - 1));
		stat.out_busy = rsp_valid_q && rsp_stall;
	end

	always_comb begin
		rd_en   = issue || cmd.swap_rd;
		rd_addr = cmd.swap_rd ? slot : idx_q;
		we      = 1'b0;
		wr_addr = slot;
		wr_data = hit_ent_q;
		if (cmd.swap_a) begin
			we = 1'b1;
		end
		if (cmd.swap_b) begin
			we      = 1'b1;
			wr_addr = hit_idx_q;
			wr_data = rdata_s1;
		end
		if (cmd.fill) begin
			we               = 1'b1;
			wr_data.writable = req_q.write_access;
			wr_data.host     = req_q.host_page_base;
			wr_data.tag      = vpage;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
		if (issue) begin
			idx_s1  <= idx_q;
			step_s1 <= iss_q[IW-1:0];
			vbit_s1 <= valid_q[idx_q];
		end
		if (cmd.hold_hit) begin
			hit_ent_q <= rdata_s1;
			hit_idx_q <= idx_s1;
		end
		if (cmd.out_load) begin
			rsp_q.hit       <= hit_q;
			rsp_q.host_addr <= hit_q ? {hit_ent_q.host, req_q.virt_addr[OFFSET_W-1:0]}
				: '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			ptr_q       <= '0;
			idx_q       <= '0;
			iss_q       <= '0;
			live_s1     <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			live_s1 <= issue;
			if (cmd.accept) begin
				idx_q <= ptr_q;
				iss_q <= '0;
				hit_q <= 1'b0;
			end else if (issue) begin
				idx_q <= (idx_q == IW'(ENTRIES - 1)) ? '0 : idx_q + IW'(1);
				iss_q <= iss_q + CW'(1);
			end
			if (cmd.hold_hit) begin
				hit_q <= 1'b1;
			end
			if (cmd.swap_b) begin
				valid_q[hit_idx_q] <= valid_q[slot];
				valid_q[slot]      <= 1'b1;
				ptr_q              <= slot;
			end
			if (cmd.fill) begin
				valid_q[slot] <= 1'b1;
				ptr_q         <= slot;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ design/ptcp_checker.sv @@
// ----------------------------------------------------------------------------
// ptcp_checker
// Port-level checks on the page translation cache, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_translation_cache_promote_core_macros.svh"

module ptcp_checker
	import ptcp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_beat_t req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_beat_t rsp
);

	logic req_take;

	assign req_take = req_valid && !req_stall;

	`PTCP_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp beat changed while stalled")
	`PTCP_ASSERT_NEXT(a_req_hold, clk, arst_n, req_valid && req_stall, req_valid && $stable(req), "req beat changed while stalled")
	`PTCP_ASSERT_SAME(a_miss_zero, clk, arst_n, rsp_valid && !rsp.hit, rsp.host_addr == '0, "miss or fill beat carries a nonzero address")
	`PTCP_ASSERT_NEXT(a_one_item, clk, arst_n, req_take, req_stall && !$past(req_stall), "req taken while an item is in work")
	`PTCP_ASSERT_SAME(a_rsp_cause, clk, arst_n, $rose(rsp_valid), $past(req_stall), "rsp beat without an item in work")

endmodule

bind page_translation_cache_promote_core ptcp_checker u_ptcp_checker (.*);

@@ sim/tb_page_translation_cache_promote_core.sv @@
// ----------------------------------------------------------------------------
// tb_page_translation_cache_promote_core
// Self-checking bench for the page translation cache. Fills and lookups are
// driven with random gaps and response stalls. Each accepted request updates
// a cycle-free copy of the cache, including promotions, and the expected hit
// flag and host address are queued. Each accepted response is checked
// against the oldest queued translation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_page_translation_cache_promote_core;
	import ptcp_pkg::*;

	localparam int ENTRIES      = 16;
	localparam int PROMOTE_DIST = 3;
	localparam int POOL         = 24;
	localparam int RANDOM_ITEMS = 650;
	localparam int LONG_HOLD    = 300;

	class ptcp_scoreboard;
		logic [PAGE_W-1:0] tag_pg  [ENTRIES];
		logic [PAGE_W-1:0] host_pg [ENTRIES];
		bit                valid   [ENTRIES];
		bit                writable[ENTRIES];
		int unsigned       ptr;
		rsp_beat_t         expected_translations[$];
		int unsigned       mismatches, checked, fills, hits, misses, promotions;

		function new();
			ptr = 0;
			foreach (valid[i]) begin
				valid[i]    = 1'b0;
				writable[i] = 1'b0;
				tag_pg[i]   = '0;
				host_pg[i]  = '0;
			end
		endfunction

		function void note_request(req_beat_t b);
			rsp_beat_t         e;
			logic [PAGE_W-1:0] vpage, t_tag, t_host;
			bit                t_v, t_w, found;
			int unsigned       idx, slot, n, hit_step;
			e        = '0;
			found    = 1'b0;
			hit_step = 0;
			vpage    = b.virt_addr[ADDR_W-1:OFFSET_W];
			idx      = ptr;
			if (b.kind == KIND_FILL) begin
				ptr           = (ptr == 0) ? ENTRIES - 1 : ptr - 1;
				tag_pg[ptr]   = vpage;
				host_pg[ptr]  = b.host_page_base;
				valid[ptr]    = 1'b1;
				writable[ptr] = b.write_access;
				fills++;
			end else begin
				for (n = 0; n < ENTRIES; n++) begin
					if (!found && valid[idx] && tag_pg[idx] == vpage &&
						(writable[idx] || !b.write_access)) begin
						found    = 1'b1;
						hit_step = n;
					end
					if (!found)
						idx = (idx + 1) % ENTRIES;
				end
				if (found) begin
					slot = idx;
					if (hit_step >= PROMOTE_DIST) begin
						// swap the far hit into the slot just before the pointer
						slot           = (ptr == 0) ? ENTRIES - 1 : ptr - 1;
						t_tag          = tag_pg[slot];
						t_host         = host_pg[slot];
						t_v            = valid[slot];
						t_w            = writable[slot];
						tag_pg[slot]   = tag_pg[idx];
						host_pg[slot]  = host_pg[idx];
						valid[slot]    = valid[idx];
						writable[slot] = writable[idx];
						tag_pg[idx]    = t_tag;
						host_pg[idx]   = t_host;
						valid[idx]     = t_v;
						writable[idx]  = t_w;
						ptr            = slot;
						promotions++;
					end
					e.hit       = 1'b1;
					e.host_addr = {host_pg[slot], b.virt_addr[OFFSET_W-1:0]};
					hits++;
				end else begin
					misses++;
				end
			end
			expected_translations.push_back(e);
		endfunction

		function void check_response(rsp_beat_t a);
			rsp_beat_t e;
			if (expected_translations.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected response hit=%0b host_addr=%h",
						$time, a.hit, a.host_addr);
			end else begin
				e = expected_translations.pop_front();
				checked++;
				if (a.hit !== e.hit || a.host_addr !== e.host_addr) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch hit exp=%0b act=%0b host_addr exp=%h act=%h",
							$time, e.hit, a.hit, e.host_addr, a.host_addr);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_translations.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_beat_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_beat_t rsp;

	ptcp_scoreboard    sb = new();
	logic [PAGE_W-1:0] page_pool[POOL];
	int unsigned       quiet_left;
	logic              hold_request;

	page_translation_cache_promote_core #(
		.ENTRIES         (ENTRIES),
		.PROMOTE_DISTANCE(PROMOTE_DIST)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [ADDR_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [PAGE_W-1:0] rand_page();
		return PAGE_W'(rand64());
	endfunction

	task automatic send_beat(input logic kind, input logic [ADDR_W-1:0] va,
		input logic wr, input logic [PAGE_W-1:0] hb);
		req_beat_t   b;
		int unsigned gap, r;
		b.kind           = kind;
		b.virt_addr      = va;
		b.write_access   = wr;
		b.host_page_base = hb;
		if (quiet_left > 0) begin
			quiet_left--;
			gap = 0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				quiet_left = $urandom_range(20, 60);
				gap        = 0;
			end else if (r < 55)
				gap = 0;
			else if (r < 90)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(6, 30);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= b;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		sb.note_request(b);
	endtask

	task automatic wait_for_drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// response side: random stalls, one long hold on request
	initial begin
		int unsigned stall_left, open_left, r;
		bit          hold_taken;
		stall_left = 0;
		open_left  = 0;
		hold_taken = 1'b0;
		rsp_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall == 1'b0)
				sb.check_response(rsp);
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = LONG_HOLD;
				open_left  = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (open_left > 0) begin
				open_left--;
				rsp_stall <= 1'b0;
			end else begin
				r          = $urandom_range(0, 99);
				open_left  = (r < 15) ? $urandom_range(40, 120) : $urandom_range(0, 5);
				r          = $urandom_range(0, 99);
				stall_left = (r < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int unsigned       k, r;
		logic [PAGE_W-1:0] pg, hb;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		hold_request = 1'b0;
		quiet_left   = 0;
		page_pool[0] = '1;
		page_pool[1] = '0;
		for (k = 2; k < POOL; k++)
			page_pool[k] = rand_page();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every slot; first page is read-only at the top of the address space
		send_beat(KIND_FILL, '1, 1'b0, '1);
		send_beat(KIND_FILL, '0, 1'b1, '0);
		for (k = 2; k < ENTRIES; k++)
			send_beat(KIND_FILL, {page_pool[k], OFFSET_W'($urandom())}, k % 3 != 0,
				rand_page());
		// far hit onto the slot before the pointer, then near, mid and far hits
		send_beat(KIND_LOOKUP, '1, 1'b0, '0);
		send_beat(KIND_LOOKUP, {page_pool[0], 12'h000}, 1'b0, '0);
		send_beat(KIND_LOOKUP, {page_pool[15], 12'h5a5}, 1'b0, '0);
		send_beat(KIND_LOOKUP, {page_pool[14], 12'h123}, 1'b1, '0);
		send_beat(KIND_LOOKUP, {page_pool[13], 12'hfff}, 1'b0, '0);
		// write to a read-only page, an unknown page, address zero
		send_beat(KIND_LOOKUP, '1, 1'b1, '1);
		send_beat(KIND_LOOKUP, rand64(), 1'b0, rand_page());
		send_beat(KIND_LOOKUP, '0, 1'b1, '0);
		wait_for_drain();

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == 200) begin
				hold_request <= 1'b1;
				quiet_left = 80;
			end
			if (k == 420)
				wait_for_drain();
			pg = ($urandom_range(0, 9) == 0) ? rand_page()
				: page_pool[$urandom_range(0, POOL - 1)];
			r = $urandom_range(0, 19);
			hb = (r == 0) ? '1 : (r == 1) ? '0 : rand_page();
			r = $urandom_range(0, 99);
			if (r < 30)
				send_beat(KIND_FILL, {pg, OFFSET_W'($urandom())},
					1'($urandom_range(0, 1)), hb);
			else if (r < 90)
				send_beat(KIND_LOOKUP, {pg, OFFSET_W'($urandom())},
					$urandom_range(0, 2) == 0, hb);
			else
				send_beat(KIND_LOOKUP, rand64(), 1'($urandom_range(0, 1)), hb);
		end
		req_valid <= 1'b0;
		wait_for_drain();
		repeat (2 * ENTRIES + 10) @(posedge clk);

		$display("Checked %0d responses: %0d fills, %0d hits, %0d misses, %0d promotions",
			sb.checked, sb.fills, sb.hits, sb.misses, sb.promotions);
		$display("Mismatches: %0d, responses still owed: %0d", sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/ptcp_pkg.sv
design/ptcp_ctrl.sv
design/ptcp_dpath.sv
design/page_translation_cache_promote_core.sv
design/ptcp_checker.sv
sim/tb_page_translation_cache_promote_core.sv
